@@ rtl/trme_pkg.sv @@
package trme_pkg;

   localparam int MODE_W    = 3;
   localparam int REG_IDX_W = 3;
   localparam int IMM_W     = 32;
   localparam int PLEN_W    = 10;

   localparam logic [MODE_W-1:0] OP_LET   = 3'd0;
   localparam logic [MODE_W-1:0] OP_ADD   = 3'd1;
   localparam logic [MODE_W-1:0] OP_SUB   = 3'd2;
   localparam logic [MODE_W-1:0] OP_MUL   = 3'd3;
   localparam logic [MODE_W-1:0] OP_DIV   = 3'd4;
   localparam logic [MODE_W-1:0] OP_PRINT = 3'd5;
   localparam logic [MODE_W-1:0] OP_BGE   = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic read_live;
      logic capture;
      logic mdu_start;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_mdu;
      logic mdu_busy;
   } status_type;

endpackage

@@ rtl/trme_ram.sv @@
module trme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 6
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   output logic [WIDTH-1:0]         rdata0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

@@ rtl/trme_mdu.sv @@
module trme_mdu
   import trme_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  is_div,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output logic                  busy,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int DW   = DATA_WIDTH;
   localparam int CNTW = $clog2(DW + 1);

   logic [DW:0]      acc_ff, acc_in;
   logic [DW-1:0]    opnd_ff, opnd_in;
   logic [DW-1:0]    shift_ff, shift_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             neg_ff, neg_in;
   logic             div_ff, div_in;
   logic [DW-1:0]    abs_a, abs_b;
   logic [DW:0]      trial;
   logic             trial_ge;

   assign abs_a    = opa[DW-1] ? (DW'(0) - opa) : opa;
   assign abs_b    = opb[DW-1] ? (DW'(0) - opb) : opb;
   assign trial    = {acc_ff[DW-1:0], shift_ff[DW-1]};
   assign trial_ge = trial >= {1'b0, opnd_ff};

   always_comb begin
      acc_in   = acc_ff;
      opnd_in  = opnd_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      if (start) begin
         // Divide works on magnitudes; the quotient sign is fixed at the end.
         busy_in = 1'b1;
         cnt_in  = CNTW'(DW);
         div_in  = is_div;
         acc_in  = '0;
         if (is_div) begin
            opnd_in  = abs_b;
            shift_in = abs_a;
            neg_in   = opa[DW-1] ^ opb[DW-1];
         end else begin
            opnd_in  = opa;
            shift_in = opb;
            neg_in   = 1'b0;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in   = trial_ge ? (trial - {1'b0, opnd_ff}) : trial;
            shift_in = {shift_ff[DW-2:0], trial_ge};
         end else begin
            acc_in   = {1'b0, acc_ff[DW-1:0] + (shift_ff[0] ? opnd_ff : DW'(0))};
            opnd_in  = {opnd_ff[DW-2:0], 1'b0};
            shift_in = {1'b0, shift_ff[DW-1:1]};
         end
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      opnd_ff  <= opnd_in;
      shift_ff <= shift_in;
      neg_ff   <= neg_in;
      div_ff   <= div_in;
   end

   assign busy   = busy_ff;
   assign result = div_ff ? (neg_ff ? (DW'(0) - shift_ff) : shift_ff) : acc_ff[DW-1:0];

endmodule

@@ rtl/trme_datapath.sv @@
module trme_datapath
   import trme_pkg::*;
#(
   parameter int NUM_REGS      = 6,
   parameter int DATA_WIDTH    = 32,
   parameter int PROGRAM_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmd_type                              cmd,
   output status_type                           status,
   input  logic [MODE_W-1:0]                    req_mode,
   input  logic [REG_IDX_W-1:0]                 req_dest_reg,
   input  logic [REG_IDX_W-1:0]                 req_src_a_reg,
   input  logic [REG_IDX_W-1:0]                 req_src_b_reg,
   input  logic signed [IMM_W-1:0]              req_immediate,
   input  logic                                 csr_we,
   input  logic [PLEN_W-1:0]                    csr_wdata,
   output logic [$clog2(PROGRAM_DEPTH+1)-1:0]   rsp_next_pc,
   output logic                                 rsp_halted,
   output logic                                 rsp_print_valid,
   output logic [REG_IDX_W-1:0]                 rsp_print_index,
   output logic signed [DATA_WIDTH-1:0]         rsp_print_value,
   output logic                                 rsp_div_by_zero
);

   localparam int DW  = DATA_WIDTH;
   localparam int AW  = $clog2(NUM_REGS);
   localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
   localparam int CW  = (PCW > PLEN_W) ? PCW : PLEN_W;

   logic [MODE_W-1:0]    mode_ff;
   logic [REG_IDX_W-1:0] dest_ff, srca_ff, srcb_ff;
   logic [IMM_W-1:0]     imm_ff;
   logic [PCW-1:0]       pc_ff, npc;
   logic [PLEN_W-1:0]    plen_ff;
   logic [2**AW-1:0]     vld_ff, vld_in;
   logic                 ok0_ff, ok1_ff;

   logic [MODE_W-1:0]    rd_mode;
   logic [REG_IDX_W-1:0] rd_dest, rd_srca, rd_srcb, idx0, idx1;
   logic [AW+REG_IDX_W-1:0] wide0, wide1, widew;
   logic [AW-1:0]        addr0, addr1, waddr;
   logic                 inr0, inr1, inrw;
   logic [DW-1:0]        rdata0, rdata1, rd0, rd1, wdata, mdu_result;
   logic [63:0]          imm_ext;
   logic                 halted_now, taken, div_zero, we, is_print;
   logic [PCW-1:0]       pc_inc, br_target;

   // Register read addresses come straight from the request while idle, so the
   // read data is ready in the cycle after an item is accepted.
   assign rd_mode = cmd.read_live ? req_mode      : mode_ff;
   assign rd_dest = cmd.read_live ? req_dest_reg  : dest_ff;
   assign rd_srca = cmd.read_live ? req_src_a_reg : srca_ff;
   assign rd_srcb = cmd.read_live ? req_src_b_reg : srcb_ff;
   assign idx0 = (rd_mode == OP_PRINT || rd_mode == OP_BGE) ? rd_dest : rd_srca;
   assign idx1 = (rd_mode == OP_BGE) ? rd_srca : rd_srcb;

   assign wide0 = {{AW{1'b0}}, idx0};
   assign wide1 = {{AW{1'b0}}, idx1};
   assign widew = {{AW{1'b0}}, dest_ff};
   assign addr0 = wide0[AW-1:0];
   assign addr1 = wide1[AW-1:0];
   assign waddr = widew[AW-1:0];
   assign inr0  = 32'(idx0) < 32'(NUM_REGS);
   assign inr1  = 32'(idx1) < 32'(NUM_REGS);
   assign inrw  = 32'(dest_ff) < 32'(NUM_REGS);

   trme_ram #(
      .WIDTH(DW),
      .DEPTH(NUM_REGS)
   ) u_regs (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr0(addr0),
      .rdata0(rdata0),
      .raddr1(addr1),
      .rdata1(rdata1)
   );

   // Never-written and out-of-range registers read as zero.
   assign rd0 = ok0_ff ? rdata0 : '0;
   assign rd1 = ok1_ff ? rdata1 : '0;

   trme_mdu #(
      .DATA_WIDTH(DW)
   ) u_mdu (
      .clock (clock),
      .reset (reset),
      .start (cmd.mdu_start),
      .is_div(mode_ff == OP_DIV),
      .opa   (rd0),
      .opb   (rd1),
      .busy  (status.mdu_busy),
      .result(mdu_result)
   );

   assign imm_ext    = {{32{imm_ff[IMM_W-1]}}, imm_ff};
   assign halted_now = CW'(pc_ff) > CW'(plen_ff);
   assign div_zero   = !halted_now && mode_ff == OP_DIV && rd1 == '0;
   assign is_print   = !halted_now && mode_ff == OP_PRINT;
   assign taken      = mode_ff == OP_BGE && $signed(rd0) >= $signed(rd1);
   assign pc_inc     = (pc_ff >= PCW'(PROGRAM_DEPTH)) ? PCW'(PROGRAM_DEPTH) : pc_ff + PCW'(1);

   always_comb begin
      if (imm_ff[IMM_W-1]) begin
         br_target = '0;
      end else if (imm_ff > 32'(PROGRAM_DEPTH)) begin
         br_target = PCW'(PROGRAM_DEPTH);
      end else begin
         br_target = imm_ff[PCW-1:0];
      end
   end

   assign npc = halted_now ? pc_ff : (taken ? br_target : pc_inc);

   always_comb begin
      case (mode_ff)
         OP_LET:  wdata = imm_ext[DW-1:0];
         OP_ADD:  wdata = rd0 + rd1;
         OP_SUB:  wdata = rd0 - rd1;
         default: wdata = mdu_result;
      endcase
   end

   assign we = cmd.commit && !halted_now && inrw &&
               (mode_ff == OP_LET || mode_ff == OP_ADD || mode_ff == OP_SUB ||
                mode_ff == OP_MUL || (mode_ff == OP_DIV && rd1 != '0));

   assign status.need_mdu = !halted_now &&
                            (mode_ff == OP_MUL || (mode_ff == OP_DIV && rd1 != '0));

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PCW'(1);
         plen_ff <= '0;
         vld_ff  <= '0;
         ok0_ff  <= 1'b0;
         ok1_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            pc_ff <= npc;
         end
         if (csr_we) begin
            plen_ff <= csr_wdata;
         end
         vld_ff <= vld_in;
         ok0_ff <= inr0 && vld_ff[addr0];
         ok1_ff <= inr1 && vld_ff[addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         dest_ff <= req_dest_reg;
         srca_ff <= req_src_a_reg;
         srcb_ff <= req_src_b_reg;
         imm_ff  <= req_immediate;
      end
      if (cmd.commit) begin
         rsp_next_pc     <= npc;
         rsp_halted      <= halted_now || (CW'(npc) > CW'(plen_ff));
         rsp_print_valid <= is_print;
         rsp_print_index <= is_print ? dest_ff : '0;
         rsp_print_value <= is_print ? rd0 : '0;
         rsp_div_by_zero <= div_zero;
      end
   end

endmodule

@@ rtl/trme_ctrl.sv @@
module trme_ctrl
   import trme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, accept;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && state_ff == ST_IDLE;

   always_comb begin
      state_in      = state_ff;
      cmd.read_live = 1'b0;
      cmd.capture   = 1'b0;
      cmd.mdu_start = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.read_live = 1'b1;
            cmd.capture   = accept;
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.need_mdu) begin
               cmd.mdu_start = 1'b1;
               state_in      = ST_WAIT;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (!status.mdu_busy && out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/toy_register_machine_execute.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    mode, dest_reg, src_a_reg, src_b_reg, immediate
// rsp_      out        rsp_valid/rsp_ready    next_pc, halted, print_*, div_by_zero
// csr_      in         csr_we                 program_length (csr_wdata)
//
// Let, add, sub, print, bge, unused-mode, divide-by-zero and halted steps load the
// result register from the execute state once it is free. Mul and div pass from
// the execute state through the one-bit-per-cycle multiply/divide unit and the
// wait state before they reach the result register. Reset is synchronous; the
// register file reads as zero until written. One item is in flight at a time; a
// new item is taken while a finished result waits, and a full result register
// holds back only the next commit.
module toy_register_machine_execute
   import trme_pkg::*;
#(
   parameter int NUM_REGS      = 6,
   parameter int DATA_WIDTH    = 32,
   parameter int PROGRAM_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [MODE_W-1:0]                    req_mode,
   input  logic [REG_IDX_W-1:0]                 req_dest_reg,
   input  logic [REG_IDX_W-1:0]                 req_src_a_reg,
   input  logic [REG_IDX_W-1:0]                 req_src_b_reg,
   input  logic signed [IMM_W-1:0]              req_immediate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [$clog2(PROGRAM_DEPTH+1)-1:0]   rsp_next_pc,
   output logic                                 rsp_halted,
   output logic                                 rsp_print_valid,
   output logic [REG_IDX_W-1:0]                 rsp_print_index,
   output logic signed [DATA_WIDTH-1:0]         rsp_print_value,
   output logic                                 rsp_div_by_zero,
   input  logic                                 csr_we,
   input  logic [PLEN_W-1:0]                    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   trme_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   trme_datapath #(
      .NUM_REGS     (NUM_REGS),
      .DATA_WIDTH   (DATA_WIDTH),
      .PROGRAM_DEPTH(PROGRAM_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_dest_reg   (req_dest_reg),
      .req_src_a_reg  (req_src_a_reg),
      .req_src_b_reg  (req_src_b_reg),
      .req_immediate  (req_immediate),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_halted     (rsp_halted),
      .rsp_print_valid(rsp_print_valid),
      .rsp_print_index(rsp_print_index),
      .rsp_print_value(rsp_print_value),
      .rsp_div_by_zero(rsp_div_by_zero)
   );

endmodule

@@ rtl/trme_checker.sv @@
module trme_checker
   import trme_pkg::*;
#(
   parameter int DATA_WIDTH    = 32,
   parameter int PROGRAM_DEPTH = 1024
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [$clog2(PROGRAM_DEPTH+1)-1:0] rsp_next_pc,
   input logic                               rsp_print_valid,
   input logic signed [DATA_WIDTH-1:0]       rsp_print_value,
   input logic                               rsp_div_by_zero
);

   localparam int PCW = $clog2(PROGRAM_DEPTH + 1);

   // The block runs one item at a time, so it is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while the previous item was still at work");

   a_pc_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_pc <= PCW'(PROGRAM_DEPTH))
      else $error("next_pc beyond the program depth");

   a_print_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |-> !rsp_div_by_zero)
      else $error("print and divide-by-zero flagged on the same item");

   a_print_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_value == '0)
      else $error("print value nonzero without a print");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("result dropped or changed while stalled");

endmodule

bind toy_register_machine_execute trme_checker #(
   .DATA_WIDTH   (DATA_WIDTH),
   .PROGRAM_DEPTH(PROGRAM_DEPTH)
) u_trme_checker (.*);
